// ===== sv/sfas_pkg.sv =====
// Package for the single-precision add/subtract pipeline.
// Holds field constants, status codes and the leading-zero helper; no dependencies.
package sfas_pkg;

  localparam int unsigned MantW = 24;
  localparam int unsigned ExpW  = 8;
  localparam logic [7:0]  ExpMax = 8'hFF;

  typedef enum logic [1:0] {
    StNormal    = 2'd0,
    StZero      = 2'd1,
    StOverflow  = 2'd2,
    StUnderflow = 2'd3
  } status_e;

  // Count of leading zeros in a 24-bit mantissa (input known nonzero).
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd0;
    hit = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!hit && v[i]) begin
        hit = 1'b1;
        n   = 5'(23 - i);
      end
    end
    return n;
  endfunction

endpackage

// ===== sv/single_float_add_sub.sv =====
// Single-precision floating-point add/subtract, truncating, four-stage pipeline.
// An operation enters every cycle when the output side keeps up; its result word
// passes through the stages align, add, count and pack.
// All stages advance together under one enable, so a stall holds every stage.
// NaN, infinity and denormal inputs get no special handling. Depends on sfas_pkg.
module single_float_add_sub import sfas_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
  input  logic        s_axis_tuser,   // command[0]: 0 add, 1 subtract
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // result_bits[31:0], status[33:32], zero fill
);

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;

  // Stage 1 registers: aligned mantissas.
  logic        s1_sa_q, s1_sb_q;
  logic [7:0]  s1_e_q;
  logic [23:0] s1_ma_q, s1_mb_q;
  // Stage 2 registers: raw magnitude.
  logic        s2_s_q;
  logic [7:0]  s2_e_q;
  logic [24:0] s2_sum_q;
  // Stage 3 registers: normalization amount.
  logic        s3_s_q, s3_ovf_q;
  logic [7:0]  s3_e_q;
  logic [24:0] s3_sum_q;
  logic [4:0]  s3_lz_q;
  // Stage 4: output word.
  logic [31:0] res_q;
  status_e     st_q;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {6'd0, st_q, res_q};

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q} <= '0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 1: unpack and align the smaller-exponent operand.
  logic [31:0] a_w, b_w;
  logic [7:0]  ea, eb, dab, dba;
  logic [23:0] ma, mb;
  always_comb begin
    a_w = s_axis_tdata[31:0];
    b_w = s_axis_tdata[63:32];
    ea  = a_w[30:23];
    eb  = b_w[30:23];
    ma  = {1'b1, a_w[22:0]};
    mb  = {1'b1, b_w[22:0]};
    dab = ea - eb;
    dba = eb - ea;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sa_q <= a_w[31];
      s1_sb_q <= b_w[31] ^ s_axis_tuser;
      if (ea > eb) begin
        s1_e_q  <= ea;
        s1_ma_q <= ma;
        s1_mb_q <= (dab >= 8'd24) ? 24'd0 : (mb >> dab);
      end else begin
        s1_e_q  <= eb;
        s1_mb_q <= mb;
        s1_ma_q <= (dba >= 8'd24) ? 24'd0 : (ma >> dba);
      end
    end
  end

  // Stage 2: add or subtract magnitudes; sign follows the larger one, b's on a tie.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_e_q <= s1_e_q;
      if (s1_sa_q == s1_sb_q) begin
        s2_sum_q <= {1'b0, s1_ma_q} + {1'b0, s1_mb_q};
        s2_s_q   <= s1_sa_q;
      end else if (s1_ma_q > s1_mb_q) begin
        s2_sum_q <= {1'b0, s1_ma_q - s1_mb_q};
        s2_s_q   <= s1_sa_q;
      end else begin
        s2_sum_q <= {1'b0, s1_mb_q - s1_ma_q};
        s2_s_q   <= s1_sb_q;
      end
    end
  end

  // Stage 3: find the normalize direction and distance.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_s_q   <= s2_s_q;
      s3_e_q   <= s2_e_q;
      s3_sum_q <= s2_sum_q;
      s3_ovf_q <= s2_sum_q[24];
      s3_lz_q  <= lzc24(s2_sum_q[23:0]);
    end
  end

  // Stage 4: shift, adjust the exponent and pack with range checks.
  logic [9:0]  e_n;
  logic [23:0] m_n;
  always_comb begin
    if (s3_ovf_q) begin
      e_n = {2'b00, s3_e_q} + 10'd1;
      m_n = s3_sum_q[24:1];
    end else begin
      e_n = {2'b00, s3_e_q} - {5'd0, s3_lz_q};
      m_n = s3_sum_q[23:0] << s3_lz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s3_sum_q == 25'd0) begin
        res_q <= 32'd0;
        st_q  <= StZero;
      end else if (!e_n[9] && e_n[8:0] >= 9'd255) begin
        res_q <= {s3_s_q, ExpMax, 23'd0};
        st_q  <= StOverflow;
      end else if (e_n[9] || e_n == 10'd0) begin
        res_q <= {s3_s_q, 31'd0};
        st_q  <= StUnderflow;
      end else begin
        res_q <= {s3_s_q, e_n[7:0], m_n[22:0]};
        st_q  <= StNormal;
      end
    end
  end

  // Checks.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st_q == StZero |-> res_q == 32'd0)
    else $error("exact zero not packed as plus zero");
  a_inf_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st_q == StOverflow |-> res_q[30:0] == {ExpMax, 23'd0})
    else $error("overflow not packed as infinity");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && adv |=> m_axis_tvalid)
    else $error("valid lost in pipeline");

endmodule
